// File: rtl/vgts_pkg.sv
// Shared types and constants of the voxel grid trilinear sampler.
// Depends on nothing; every other file but vgts_ram refers to it by scoped names.
package vgts_pkg;

  localparam int IDX_W = 10;
  localparam int FRC_W = 16;

  typedef enum logic [1:0] {
    CFG_SCALE_X = 2'd0,
    CFG_SCALE_Y = 2'd1,
    CFG_SCALE_Z = 2'd2,
    CFG_TRI_EN  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic [19:0]        pos_x;
    logic [19:0]        pos_y;
    logic [19:0]        pos_z;
    logic [4:0]         voxel_x;
    logic [4:0]         voxel_y;
    logic [4:0]         voxel_z;
    logic signed [15:0] voxel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               clamped;
  } out_item_t;

  typedef struct packed {
    logic [15:0] scale_x;
    logic [15:0] scale_y;
    logic [15:0] scale_z;
    logic        tri_en;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] i1;
    logic [FRC_W-1:0] f;
    logic             cl;
  } axis_t;

  typedef struct packed {
    logic        is_write;
    logic        tri_en;
    logic        clamped;
    axis_t       ax;
    axis_t       ay;
    axis_t       az;
    logic [15:0] value;
  } cmd_t;

endpackage

// File: rtl/vgts_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module vgts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/vgts_cmd_fifo.sv
// Two-entry command queue between the front and the back of the sampler.
// Depends on vgts_pkg for the command type.
module vgts_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vgts_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vgts_pkg::cmd_t head
);

  vgts_pkg::cmd_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt  = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rp_nxt  = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push && !full) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/vgts_front.sv
// Front of the sampler: takes items, scales positions and splits them into voxel indices
// and fractions (or rounds to the nearest index), and queues commands. Depends on vgts_pkg.
module vgts_front #(
  parameter int GRID_X    = 32,
  parameter int GRID_Y    = 32,
  parameter int GRID_Z    = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vgts_pkg::cfg_t     cfg,
  input  logic               in_push,
  output logic               in_full,
  input  vgts_pkg::in_item_t in_data,
  output logic               q_push,
  output vgts_pkg::cmd_t     q_cmd,
  input  logic               q_full
);

  localparam int CW = 16 + FRAC_BITS;
  localparam int SH = 20 - FRAC_BITS;
  localparam logic [CW:0] HALF = (CW + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fst_t;

  fst_t               st_r;
  vgts_pkg::in_item_t item_r;
  logic [CW-1:0]      cx_r, cy_r, cz_r;
  logic [35:0]        px, py, pz;
  logic               in_grid;

  function automatic vgts_pkg::axis_t split_axis(input logic [CW-1:0] c,
                                                 input logic [16:0] gm,
                                                 input logic tri_en);
    logic [16:0]          i;
    logic [FRAC_BITS-1:0] f;
    logic [16:0]          r;
    logic [CW:0]          cr;
    vgts_pkg::axis_t      a;
    i  = {1'b0, c[CW-1:FRAC_BITS]};
    f  = c[FRAC_BITS-1:0];
    cr = {1'b0, c} + HALF;
    r  = cr[CW:FRAC_BITS];
    a  = '0;
    if (tri_en) begin
      if (i > gm || (i == gm && f != '0)) begin
        a.i0 = gm[vgts_pkg::IDX_W-1:0];
        a.i1 = gm[vgts_pkg::IDX_W-1:0];
        a.cl = 1'b1;
      end else begin
        a.i0 = i[vgts_pkg::IDX_W-1:0];
        a.i1 = i[vgts_pkg::IDX_W-1:0] + vgts_pkg::IDX_W'(f != '0);
        a.f  = vgts_pkg::FRC_W'(f);
      end
    end else begin
      if (r > gm) begin
        a.i0 = gm[vgts_pkg::IDX_W-1:0];
        a.cl = 1'b1;
      end else begin
        a.i0 = r[vgts_pkg::IDX_W-1:0];
      end
      a.i1 = a.i0;
    end
    return a;
  endfunction

  assign px = 36'(item_r.pos_x) * 36'(cfg.scale_x);
  assign py = 36'(item_r.pos_y) * 36'(cfg.scale_y);
  assign pz = 36'(item_r.pos_z) * 36'(cfg.scale_z);

  assign in_full = (st_r != F_IDLE);
  assign in_grid = (32'(item_r.voxel_x) < GRID_X) && (32'(item_r.voxel_y) < GRID_Y)
                   && (32'(item_r.voxel_z) < GRID_Z);

  always_comb begin
    q_cmd = '0;
    q_cmd.value = item_r.voxel_value;
    if (item_r.func == vgts_pkg::FUNC_WRITE) begin
      q_cmd.is_write = 1'b1;
      q_cmd.ax.i0 = vgts_pkg::IDX_W'(item_r.voxel_x);
      q_cmd.ay.i0 = vgts_pkg::IDX_W'(item_r.voxel_y);
      q_cmd.az.i0 = vgts_pkg::IDX_W'(item_r.voxel_z);
    end else begin
      q_cmd.tri_en = cfg.tri_en;
      q_cmd.ax = split_axis(cx_r, 17'(GRID_X - 1), cfg.tri_en);
      q_cmd.ay = split_axis(cy_r, 17'(GRID_Y - 1), cfg.tri_en);
      q_cmd.az = split_axis(cz_r, 17'(GRID_Z - 1), cfg.tri_en);
      q_cmd.clamped = q_cmd.ax.cl | q_cmd.ay.cl | q_cmd.az.cl;
    end
    q_push = (st_r == F_PUSH) && !q_full &&
             (item_r.func == vgts_pkg::FUNC_SAMPLE || in_grid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (in_push) begin
            item_r <= in_data;
            st_r   <= F_MUL;
          end
        end
        F_MUL: begin
          cx_r <= px[35:SH];
          cy_r <= py[35:SH];
          cz_r <= pz[35:SH];
          st_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/vgts_back.sv
// Back of the sampler: executes voxel writes and reads and blends the corners
// through a multiply pipeline into the result register. Depends on vgts_pkg, vgts_ram.
module vgts_back #(
  parameter int GRID_X    = 32,
  parameter int GRID_Y    = 32,
  parameter int GRID_Z    = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vgts_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output vgts_pkg::out_item_t out_data
);

  localparam int AW   = $clog2(GRID_X * GRID_Y * GRID_Z);
  localparam int WW   = FRAC_BITS + 1;
  localparam int P1W  = 16 + WW;
  localparam int P2W  = 16 + 2 * WW;
  localparam int P3W  = 16 + 3 * WW;
  localparam int ACCW = 17 + 3 * FRAC_BITS;
  localparam logic [WW-1:0]   ONE   = WW'(1) << FRAC_BITS;
  localparam logic [ACCW-1:0] HALF3 = ACCW'(1) << (3 * FRAC_BITS - 1);

  typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_DRAIN} bst_t;

  bst_t             st_r;
  logic [2:0]       k_r;
  vgts_pkg::cmd_t   cmd_r;
  logic             out_valid_r;
  vgts_pkg::out_item_t out_r;
  logic             v0_r, v1_r, v2_r, v3_r;
  logic             last0_r, last1_r, last2_r, last3_r;
  logic [WW-1:0]    wx0_r, wy0_r, wz0_r, wy1_r, wz1_r, wz2_r;
  logic [P1W-1:0]   p1_r;
  logic [P2W-1:0]   p2_r;
  logic [P3W-1:0]   p3_r;
  logic [ACCW-1:0]  acc_r, sum, rnd;
  logic [15:0]      rdata, biased;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [vgts_pkg::IDX_W-1:0] cx, cy, cz;
  logic [WW-1:0]    wx, wy, wz;
  logic             last;
  logic             wr_go, rd_go;

  function automatic logic [AW-1:0] addr_of(input logic [vgts_pkg::IDX_W-1:0] x,
                                            input logic [vgts_pkg::IDX_W-1:0] y,
                                            input logic [vgts_pkg::IDX_W-1:0] z);
    logic [31:0] t;
    t = 32'(x) + 32'(GRID_X) * (32'(y) + 32'(GRID_Y) * 32'(z));
    return t[AW-1:0];
  endfunction

  vgts_ram #(.WIDTH(16), .DEPTH(GRID_X * GRID_Y * GRID_Z)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_head.value),
    .rdata (rdata)
  );

  assign wr_go = (st_r == B_IDLE) && !q_empty && q_head.is_write;
  assign rd_go = (st_r == B_IDLE) && !q_empty && !q_head.is_write && !out_valid_r;
  assign q_pop = wr_go || rd_go;
  assign ram_we = wr_go;

  assign cx = k_r[0] ? cmd_r.ax.i1 : cmd_r.ax.i0;
  assign cy = k_r[1] ? cmd_r.ay.i1 : cmd_r.ay.i0;
  assign cz = k_r[2] ? cmd_r.az.i1 : cmd_r.az.i0;
  assign wx = k_r[0] ? WW'(cmd_r.ax.f) : ONE - WW'(cmd_r.ax.f);
  assign wy = k_r[1] ? WW'(cmd_r.ay.f) : ONE - WW'(cmd_r.ay.f);
  assign wz = k_r[2] ? WW'(cmd_r.az.f) : ONE - WW'(cmd_r.az.f);
  assign last = (k_r == 3'd7) || !cmd_r.tri_en;
  assign ram_addr = wr_go ? addr_of(q_head.ax.i0, q_head.ay.i0, q_head.az.i0)
                          : addr_of(cx, cy, cz);

  assign biased = rdata ^ 16'h8000;
  assign sum    = acc_r + ACCW'(p3_r);
  assign rnd    = sum + HALF3;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      acc_r       <= '0;
    end else begin
      v0_r    <= (st_r == B_ISSUE);
      last0_r <= last;
      wx0_r   <= wx;
      wy0_r   <= wy;
      wz0_r   <= wz;
      v1_r    <= v0_r;
      last1_r <= last0_r;
      p1_r    <= P1W'(biased) * P1W'(wx0_r);
      wy1_r   <= wy0_r;
      wz1_r   <= wz0_r;
      v2_r    <= v1_r;
      last2_r <= last1_r;
      p2_r    <= P2W'(p1_r) * P2W'(wy1_r);
      wz2_r   <= wz1_r;
      v3_r    <= v2_r;
      last3_r <= last2_r;
      p3_r    <= P3W'(p2_r) * P3W'(wz2_r);
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (v3_r) begin
        if (last3_r) begin
          acc_r <= '0;
          out_r.sample_value <= rnd[3 * FRAC_BITS +: 16] ^ 16'h8000;
          out_r.clamped      <= cmd_r.clamped;
          out_valid_r        <= 1'b1;
        end else begin
          acc_r <= sum;
        end
      end
      case (st_r)
        B_IDLE: begin
          if (rd_go) begin
            cmd_r <= q_head;
            k_r   <= 3'd0;
            st_r  <= B_ISSUE;
          end
        end
        B_ISSUE: begin
          k_r <= k_r + 3'd1;
          if (last) begin
            st_r <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (v3_r && last3_r) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/voxel_grid_trilinear_sampler.sv
// Top level of the voxel grid trilinear sampler: configuration registers,
// front, command queue and back. Depends on vgts_pkg, vgts_front, vgts_cmd_fifo and vgts_back.
//
// A write item stores one voxel; a sample item passes through the front, then takes
// one voxel-store read per corner (eight in trilinear mode, one in nearest mode)
// and goes through the multiply pipeline. The single port of the voxel store and the
// one-item front limit how fast items go through. The store holds nothing at reset.
module voxel_grid_trilinear_sampler #(
  parameter int GRID_X    = 32,
  parameter int GRID_Y    = 32,
  parameter int GRID_Z    = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  vgts_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output vgts_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  vgts_pkg::cfg_t cfg_r;
  logic           q_push, q_full, q_pop, q_empty;
  vgts_pkg::cmd_t q_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x <= 16'd256;
      cfg_r.scale_y <= 16'd256;
      cfg_r.scale_z <= 16'd256;
      cfg_r.tri_en  <= 1'b1;
    end else if (cfg_valid) begin
      case (vgts_pkg::cfg_idx_t'(cfg_index))
        vgts_pkg::CFG_SCALE_X: cfg_r.scale_x <= cfg_data;
        vgts_pkg::CFG_SCALE_Y: cfg_r.scale_y <= cfg_data;
        vgts_pkg::CFG_SCALE_Z: cfg_r.scale_z <= cfg_data;
        vgts_pkg::CFG_TRI_EN:  cfg_r.tri_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vgts_front #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full)
  );

  vgts_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  vgts_back #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: rtl/vgts_checker.sv
// Port-level checks of the voxel grid trilinear sampler, bound to the top level.
// Depends on vgts_pkg and voxel_grid_trilinear_sampler.
module vgts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input vgts_pkg::out_item_t out_data,
  input logic                cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("A waiting result item changed or vanished.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("The block is not empty after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("The front took no time for an accepted item.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("The configuration port stalled.");

endmodule

bind voxel_grid_trilinear_sampler vgts_checker u_vgts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

// File: tb/sv/voxel_grid_trilinear_sampler_tb.sv
// Self-checking testbench for the voxel grid trilinear sampler.
// Predicts each sample from its own copy of the voxel grid and the scale
// registers, and checks results in order. Depends on vgts_pkg and the RTL.
class sample_scoreboard;
  logic [15:0] grid [0:32767];
  bit          written [0:32767];
  logic [15:0] scl_x, scl_y, scl_z;
  bit          tri_on;
  vgts_pkg::out_item_t pending [$];
  int          errors;

  function new();
    scl_x = 16'd256;
    scl_y = 16'd256;
    scl_z = 16'd256;
    tri_on = 1'b1;
    errors = 0;
    foreach (written[i]) written[i] = 1'b0;
  endfunction

  function void set_reg(vgts_pkg::cfg_idx_t idx, logic [15:0] val);
    case (idx)
      vgts_pkg::CFG_SCALE_X: scl_x = val;
      vgts_pkg::CFG_SCALE_Y: scl_y = val;
      vgts_pkg::CFG_SCALE_Z: scl_z = val;
      vgts_pkg::CFG_TRI_EN:  tri_on = val[0];
      default: ;
    endcase
  endfunction

  function logic [35:0] coord(logic [19:0] p, logic [15:0] s);
    logic [35:0] prod;
    prod = 36'(p) * 36'(s);
    return prod >> 12;
  endfunction

  function int unsigned biased(int x, int y, int z);
    logic [15:0] v;
    v = grid[x + 32 * (y + 32 * z)];
    return {16'd0, v ^ 16'h8000};
  endfunction

  function void split(logic [35:0] c, output int i0, output int i1,
                      output int f, inout bit cl);
    logic [35:0] i;
    i = c >> 8;
    f = int'(c[7:0]);
    if (i > 31 || (i == 31 && f != 0)) begin
      i0 = 31;
      i1 = 31;
      f = 0;
      cl = 1'b1;
    end else begin
      i0 = int'(i);
      i1 = int'(i) + int'(f != 0);
    end
  endfunction

  function int round_idx(logic [35:0] c, inout bit cl);
    logic [36:0] i;
    i = ({1'b0, c} + 37'd128) >> 8;
    if (i > 31) begin
      cl = 1'b1;
      return 31;
    end
    return int'(i);
  endfunction

  function bit reads_ok(vgts_pkg::in_item_t it);
    logic [35:0] cx, cy, cz;
    int xi[2], yi[2], zi[2];
    int fx, fy, fz;
    bit cl;
    int b;
    cl = 1'b0;
    cx = coord(it.pos_x, scl_x);
    cy = coord(it.pos_y, scl_y);
    cz = coord(it.pos_z, scl_z);
    if (tri_on) begin
      split(cx, xi[0], xi[1], fx, cl);
      split(cy, yi[0], yi[1], fy, cl);
      split(cz, zi[0], zi[1], fz, cl);
    end else begin
      xi[0] = round_idx(cx, cl);
      yi[0] = round_idx(cy, cl);
      zi[0] = round_idx(cz, cl);
      xi[1] = xi[0];
      yi[1] = yi[0];
      zi[1] = zi[0];
    end
    for (b = 0; b < 8; b++)
      if (!written[xi[b & 1] + 32 * (yi[(b >> 1) & 1] + 32 * zi[b >> 2])]) return 1'b0;
    return 1'b1;
  endfunction

  function void note_item(vgts_pkg::in_item_t it);
    vgts_pkg::out_item_t r;
    logic [35:0] cx, cy, cz;
    int xi[2], yi[2], zi[2], wx[2], wy[2], wz[2];
    int fx, fy, fz;
    bit cl;
    logic [63:0] acc;
    int b;
    if (it.func == vgts_pkg::FUNC_WRITE) begin
      grid[it.voxel_x + 32 * (it.voxel_y + 32 * it.voxel_z)] = it.voxel_value;
      written[it.voxel_x + 32 * (it.voxel_y + 32 * it.voxel_z)] = 1'b1;
      return;
    end
    cl = 1'b0;
    cx = coord(it.pos_x, scl_x);
    cy = coord(it.pos_y, scl_y);
    cz = coord(it.pos_z, scl_z);
    if (tri_on) begin
      split(cx, xi[0], xi[1], fx, cl);
      split(cy, yi[0], yi[1], fy, cl);
      split(cz, zi[0], zi[1], fz, cl);
      wx[0] = 256 - fx; wx[1] = fx;
      wy[0] = 256 - fy; wy[1] = fy;
      wz[0] = 256 - fz; wz[1] = fz;
      acc = 0;
      for (b = 0; b < 8; b++)
        acc += 64'(biased(xi[b & 1], yi[(b >> 1) & 1], zi[b >> 2]))
             * 64'(wx[b & 1] * wy[(b >> 1) & 1] * wz[b >> 2]);
      acc = (acc + 64'(1 << 23)) >> 24;
    end else begin
      acc = 64'(biased(round_idx(cx, cl), round_idx(cy, cl), round_idx(cz, cl)));
    end
    r.sample_value = acc[15:0] ^ 16'h8000;
    r.clamped = cl;
    pending.push_back(r);
  endfunction

  function void check_result(vgts_pkg::out_item_t got);
    vgts_pkg::out_item_t exp_r;
    if (pending.size() == 0) begin
      $error("result with no sample waiting: value %0d", got.sample_value);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.sample_value !== exp_r.sample_value) begin
      $error("sample_value expected %0d actual %0d", exp_r.sample_value, got.sample_value);
      errors++;
    end
    if (got.clamped !== exp_r.clamped) begin
      $error("clamped expected %0d actual %0d", exp_r.clamped, got.clamped);
      errors++;
    end
  endfunction
endclass

module voxel_grid_trilinear_sampler_tb;
  import vgts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sample_scoreboard board;
  int push_idle, pop_idle;
  bit hold_off;

  voxel_grid_trilinear_sampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(out_data);
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(in_item_t it);
    @(negedge clk);
    while (push_idle > 0 && $urandom_range(99) < push_idle) @(negedge clk);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    board.note_item(it);
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t voxel_write(int x, int y, int z, logic [15:0] v);
    in_item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.voxel_x = 5'(x);
    it.voxel_y = 5'(y);
    it.voxel_z = 5'(z);
    it.voxel_value = v;
    it.pos_x = 20'($urandom);
    it.pos_y = 20'($urandom);
    it.pos_z = 20'($urandom);
    return it;
  endfunction

  function automatic in_item_t sample_at(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
    in_item_t it;
    it = '0;
    it.func = FUNC_SAMPLE;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.voxel_x = 5'($urandom);
    it.voxel_y = 5'($urandom);
    it.voxel_z = 5'($urandom);
    it.voxel_value = 16'($urandom);
    return it;
  endfunction

  function automatic logic [19:0] rand_pos();
    case ($urandom_range(4))
      0: return 20'hFFFFF;
      1: return 20'(32'($urandom_range(32 * 4096)));
      2: return 20'(32'($urandom_range(31)) << 12);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    int k;
    int tries;
    in_item_t it;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) begin
        push_item(voxel_write($urandom, $urandom, $urandom, 16'($urandom)));
      end else begin
        tries = 0;
        do begin
          it = sample_at(rand_pos(), rand_pos(), rand_pos());
          tries++;
        end while (!board.reads_ok(it) && tries < 200);
        if (!board.reads_ok(it)) it = sample_at(20'd0, 20'd0, 20'd0);
        push_item(it);
      end
    end
  endtask

  initial begin
    int x, y, z;
    board = new();
    push_idle = 0;
    pop_idle = 0;
    hold_off = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the voxels near the origin and on the far edges; samples only
    // touch voxels that have been written.
    for (z = 0; z < 6; z++)
      for (y = 0; y < 6; y++)
        for (x = 0; x < 6; x++)
          push_item(voxel_write((x == 5) ? 31 : x, (y == 5) ? 31 : y, (z == 5) ? 31 : z,
                                16'($urandom)));
    push_item(voxel_write(0, 0, 0, 16'h8000));
    push_item(voxel_write(1, 0, 0, 16'h7FFF));
    push_item(voxel_write(31, 31, 31, 16'h7FFF));

    push_item(sample_at(20'd0, 20'd0, 20'd0));
    push_item(sample_at(20'd2048, 20'd0, 20'd0));
    push_item(sample_at(20'd2047, 20'd1, 20'd4095));
    push_item(sample_at(20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
    push_item(sample_at(20'd31 << 12, 20'd31 << 12, 20'd31 << 12));
    push_item(sample_at((20'd31 << 12) + 20'd16, 20'd0, 20'd0));
    push_item(sample_at(20'd5000, 20'd15000, 20'd13456));
    drain();

    write_reg(CFG_TRI_EN, 16'd0);
    push_item(sample_at(20'd2047, 20'd2048, 20'd0));
    push_item(sample_at((20'd31 << 12) + 20'd2048, 20'd0, 20'd0));
    push_item(sample_at(20'hFFFFF, 20'd4096, 20'd8192));
    drain();

    write_reg(CFG_SCALE_X, 16'hFFFF);
    write_reg(CFG_SCALE_Y, 16'd0);
    write_reg(CFG_SCALE_Z, 16'd1);
    write_reg(CFG_TRI_EN, 16'd1);
    push_item(sample_at(20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
    push_item(sample_at(20'd1, 20'd12345, 20'hFFFFF));
    push_item(sample_at(20'd20, 20'd1, 20'd77));

    // Long receiver hold-off so the block fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(60);
    join
    drain();

    push_idle = 10;
    pop_idle = 74;
    write_reg(CFG_SCALE_X, rand_scale());
    write_reg(CFG_SCALE_Y, rand_scale());
    write_reg(CFG_SCALE_Z, rand_scale());
    random_phase(220);
    drain();

    push_idle = 74;
    pop_idle = 10;
    write_reg(CFG_TRI_EN, 16'd0);
    write_reg(CFG_SCALE_X, 16'd256);
    write_reg(CFG_SCALE_Y, rand_scale());
    write_reg(CFG_SCALE_Z, 16'hFFFF);
    random_phase(220);
    drain();

    push_idle = 0;
    pop_idle = 0;
    write_reg(CFG_TRI_EN, 16'd1);
    write_reg(CFG_SCALE_X, rand_scale());
    write_reg(CFG_SCALE_Y, rand_scale());
    write_reg(CFG_SCALE_Z, rand_scale());
    random_phase(70);
    drain();
    write_reg(CFG_TRI_EN, 16'($urandom_range(1)));
    random_phase(50);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
